// ===== hdl/pcpd_pkg.sv =====
// Package for the point to closed polyline distance core.
// Holds widths and the sequencer state type; no dependencies.
package pcpd_pkg;
    localparam int COORD_BITS = 24;
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * (DIFF_BITS + 1);
    localparam int LEN_BITS   = 2 * DIFF_BITS + 1;
    localparam int T_BITS     = 33;
    localparam int SQ_BITS    = 2 * (DIFF_BITS + 2);
    localparam int ROOT_BITS  = SQ_BITS / 2;
    localparam int SQ_STEPS   = ROOT_BITS;
    localparam int CNT_BITS   = 6;

    typedef enum logic [10:0] {
        S_DIFF  = 11'b00000000001,
        S_LEN0  = 11'b00000000010,
        S_LEN1  = 11'b00000000100,
        S_DOT0  = 11'b00000001000,
        S_DOT1  = 11'b00000010000,
        S_DIV   = 11'b00000100000,
        S_OFFX  = 11'b00001000000,
        S_OFFY  = 11'b00010000000,
        S_SQX   = 11'b00100000000,
        S_SQY   = 11'b01000000000,
        S_ROOT  = 11'b10000000000
    } t_seg_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_seg_ctrl;
endpackage

// ===== hdl/pcpd_seg.sv =====
// Point to segment distance over a shared multiplier, divider and root step.
// Uses pcpd_pkg.
module pcpd_seg (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_px,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_py,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_by,
    output pcpd_pkg::t_seg_ctrl                    o_ctrl,
    output logic [pcpd_pkg::DIST_BITS-1:0]         o_dist
);
    localparam int DB = pcpd_pkg::DIFF_BITS;
    localparam int EB = DB + 1;
    localparam int PB = pcpd_pkg::PROD_BITS;
    localparam int LB = pcpd_pkg::LEN_BITS;
    localparam int TB = pcpd_pkg::T_BITS;
    localparam int QB = pcpd_pkg::SQ_BITS;
    localparam int RB = pcpd_pkg::ROOT_BITS;
    localparam int MB = DB + TB;

    pcpd_pkg::t_seg_state r_state;
    logic                 r_busy, r_done;
    logic [pcpd_pkg::CNT_BITS-1:0] r_cnt;
    logic signed [DB-1:0] r_abx, r_aby, r_apx, r_apy;
    logic signed [EB-1:0] r_dx, r_dy;
    logic [LB-1:0]        r_len;
    logic signed [LB:0]   r_dot;
    logic [LB:0]          r_rem;
    logic [TB-1:0]        r_t;
    logic [QB-1:0]        r_sq, r_root_rem;
    logic [RB-1:0]        r_root;
    logic [EB-1:0]        r_ma, r_mb;
    logic [DB-1:0]        r_dist;

    // shared multiplier (magnitudes)
    logic [PB-1:0] w_prod;
    assign w_prod = r_ma * r_mb;

    logic [DB-1:0] w_magx, w_magy, w_magsel;
    logic [MB-1:0] w_offp;
    logic [MB-1:0] w_offr;
    assign w_magx = r_abx[DB-1] ? DB'(-r_abx) : DB'(r_abx);
    assign w_magy = r_aby[DB-1] ? DB'(-r_aby) : DB'(r_aby);
    assign w_magsel = (r_state == pcpd_pkg::S_OFFX) ? w_magx : w_magy;
    // offset multiply: 25x33, one per cycle
    assign w_offp = MB'(w_magsel) * MB'(r_t);
    assign w_offr = w_offp + MB'(33'h080000000);

    logic signed [DB-1:0] w_off;
    logic                 w_offneg;
    assign w_offneg = (r_state == pcpd_pkg::S_OFFX) ? r_abx[DB-1] : r_aby[DB-1];
    assign w_off    = w_offneg ? -DB'(w_offr[MB-1:32]) : DB'(w_offr[MB-1:32]);

    logic [LB:0] w_rem2;
    assign w_rem2 = {r_rem[LB-1:0], 1'b0};

    logic [QB-1:0] w_trial;
    assign w_trial = QB'({r_root, 2'b01}) << (2 * r_cnt);

    logic [QB-1:0] w_sqsum;
    assign w_sqsum = r_sq + QB'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_state <= pcpd_pkg::S_DIFF;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy  <= 1'b1;
                r_state <= pcpd_pkg::S_DIFF;
                r_abx <= DB'(i_bx) - DB'(i_ax);
                r_aby <= DB'(i_by) - DB'(i_ay);
                r_apx <= DB'(i_px) - DB'(i_ax);
                r_apy <= DB'(i_py) - DB'(i_ay);
            end else if (r_busy) begin
                unique case (r_state)
                    pcpd_pkg::S_DIFF: begin
                        r_ma <= EB'(w_magx);
                        r_mb <= EB'(w_magx);
                        r_state <= pcpd_pkg::S_LEN0;
                    end
                    pcpd_pkg::S_LEN0: begin
                        r_len <= w_prod[LB-1:0];
                        r_ma <= EB'(w_magy);
                        r_mb <= EB'(w_magy);
                        r_state <= pcpd_pkg::S_LEN1;
                    end
                    pcpd_pkg::S_LEN1: begin
                        r_len <= r_len + w_prod[LB-1:0];
                        r_ma <= r_apx[DB-1] ? EB'(DB'(-r_apx)) : EB'(DB'(r_apx));
                        r_mb <= EB'(w_magx);
                        r_state <= pcpd_pkg::S_DOT0;
                    end
                    pcpd_pkg::S_DOT0: begin
                        r_dot <= (r_apx[DB-1] ^ r_abx[DB-1])
                            ? -$signed({1'b0, w_prod[LB-1:0]})
                            : $signed({1'b0, w_prod[LB-1:0]});
                        r_ma <= r_apy[DB-1] ? EB'(DB'(-r_apy)) : EB'(DB'(r_apy));
                        r_mb <= EB'(w_magy);
                        r_state <= pcpd_pkg::S_DOT1;
                    end
                    pcpd_pkg::S_DOT1: begin
                        logic signed [LB:0] v_dot;
                        v_dot = r_dot + ((r_apy[DB-1] ^ r_aby[DB-1])
                            ? -$signed({1'b0, w_prod[LB-1:0]})
                            : $signed({1'b0, w_prod[LB-1:0]}));
                        r_cnt <= '0;
                        r_t <= '0;
                        r_rem <= v_dot[LB:0];
                        if (r_len == '0 || v_dot <= 0) begin
                            r_state <= pcpd_pkg::S_OFFX;
                        end else if (v_dot >= $signed({1'b0, r_len})) begin
                            r_t <= TB'(1) << 32;
                            r_state <= pcpd_pkg::S_OFFX;
                        end else begin
                            r_state <= pcpd_pkg::S_DIV;
                        end
                    end
                    pcpd_pkg::S_DIV: begin
                        if (w_rem2 >= {1'b0, r_len}) begin
                            r_rem <= w_rem2 - {1'b0, r_len};
                            r_t   <= {r_t[TB-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2;
                            r_t   <= {r_t[TB-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == 6'd31)
                            r_state <= pcpd_pkg::S_OFFX;
                    end
                    pcpd_pkg::S_OFFX: begin
                        r_dx <= {r_apx[DB-1], r_apx} - {w_off[DB-1], w_off};
                        r_state <= pcpd_pkg::S_OFFY;
                    end
                    pcpd_pkg::S_OFFY: begin
                        r_dy <= {r_apy[DB-1], r_apy} - {w_off[DB-1], w_off};
                        r_ma <= r_dx[EB-1] ? EB'(-r_dx) : EB'(r_dx);
                        r_mb <= r_dx[EB-1] ? EB'(-r_dx) : EB'(r_dx);
                        r_state <= pcpd_pkg::S_SQX;
                    end
                    pcpd_pkg::S_SQX: begin
                        r_sq <= QB'(w_prod);
                        r_ma <= r_dy[EB-1] ? EB'(-r_dy) : EB'(r_dy);
                        r_mb <= r_dy[EB-1] ? EB'(-r_dy) : EB'(r_dy);
                        r_state <= pcpd_pkg::S_SQY;
                    end
                    pcpd_pkg::S_SQY: begin
                        r_root_rem <= w_sqsum;
                        r_root <= '0;
                        r_cnt <= pcpd_pkg::CNT_BITS'(RB - 1);
                        r_state <= pcpd_pkg::S_ROOT;
                    end
                    pcpd_pkg::S_ROOT: begin
                        // digit-by-digit root, one bit per cycle
                        if (r_root_rem >= w_trial) begin
                            r_root_rem <= r_root_rem - w_trial;
                            r_root <= {r_root[RB-2:0], 1'b1};
                        end else begin
                            r_root <= {r_root[RB-2:0], 1'b0};
                        end
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            r_state <= pcpd_pkg::S_DIFF;
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end
                    default: r_state <= pcpd_pkg::S_DIFF;
                endcase
            end
        end
    end

    // final root bit lands with r_done
    always_comb begin
        if (r_root > RB'({DB{1'b1}})) r_dist = '1;
        else r_dist = DB'(r_root);
    end

    assign o_dist = r_dist;
    assign o_ctrl = '{start: i_start, busy: r_busy, done: r_done};
endmodule

// ===== hdl/point_to_closed_polyline_distance_core.sv =====
// Minimum distance from a query point to a closed polygon, one vertex per item.
// A segment runs the 32-step divide only when the projection falls strictly inside it;
// a last vertex runs two segments (one if it is also the first vertex), and its result
// can wait on an output stall. Ready stays high after a plain first vertex and is low
// while segments run or the result is handed off; a new item is taken while a result waits.
// Reset (synchronous, active low) clears first, prev, minimum and control. Uses pcpd_seg.
module point_to_closed_polyline_distance_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_query_x,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_query_y,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_vertex_x,
    input  logic signed [pcpd_pkg::COORD_BITS-1:0] i_vertex_y,
    input  logic                                   i_last_vertex,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [pcpd_pkg::DIST_BITS-1:0]         o_distance
);
    localparam int CB = pcpd_pkg::COORD_BITS;
    typedef enum logic [3:0] {
        P_IDLE = 4'b0001, P_SEG1 = 4'b0010, P_SEG2 = 4'b0100, P_OUT = 4'b1000
    } t_top_state;

    t_top_state r_st;
    logic signed [CB-1:0] r_fx, r_fy, r_px, r_py, r_qx, r_qy, r_vx, r_vy;
    logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by;
    logic r_last, r_have, r_go, r_ovalid;
    logic [pcpd_pkg::DIST_BITS-1:0] r_best, r_out;
    pcpd_pkg::t_seg_ctrl w_ctrl;
    logic [pcpd_pkg::DIST_BITS-1:0] w_dist, w_min;

    pcpd_seg u_seg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_go),
        .i_px(r_qx), .i_py(r_qy), .i_ax(r_ax), .i_ay(r_ay), .i_bx(r_bx), .i_by(r_by),
        .o_ctrl(w_ctrl), .o_dist(w_dist)
    );

    assign w_min   = (w_dist < r_best) ? w_dist : r_best;
    assign o_ready = (r_st == P_IDLE) && !r_go;
    assign o_valid = r_ovalid;
    assign o_distance = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_st == P_OUT && (!r_ovalid || i_ready)) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= P_IDLE;
            r_fx <= '0; r_fy <= '0; r_px <= '0; r_py <= '0;
            r_best <= '1;
            r_have <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_st)
                P_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_qx <= i_query_x; r_qy <= i_query_y;
                        r_vx <= i_vertex_x; r_vy <= i_vertex_y;
                        r_last <= i_last_vertex;
                        r_px <= i_vertex_x; r_py <= i_vertex_y;
                        if (!r_have) begin
                            r_fx <= i_vertex_x; r_fy <= i_vertex_y;
                            r_have <= !i_last_vertex;
                            r_ax <= i_vertex_x; r_ay <= i_vertex_y;
                            r_bx <= i_vertex_x; r_by <= i_vertex_y;
                            if (i_last_vertex) begin
                                r_go <= 1'b1;
                                r_st <= P_SEG2;
                            end
                        end else begin
                            r_ax <= r_px; r_ay <= r_py;
                            r_bx <= i_vertex_x; r_by <= i_vertex_y;
                            r_go <= 1'b1;
                            r_st <= P_SEG1;
                        end
                    end
                end
                P_SEG1: begin
                    if (w_ctrl.done) begin
                        r_best <= w_min;
                        if (r_last) begin
                            r_have <= 1'b0;
                            r_ax <= r_vx; r_ay <= r_vy;
                            r_bx <= r_fx; r_by <= r_fy;
                            r_go <= 1'b1;
                            r_st <= P_SEG2;
                        end else begin
                            r_st <= P_IDLE;
                        end
                    end
                end
                P_SEG2: begin
                    if (w_ctrl.done) begin
                        r_best <= w_min;
                        r_st <= P_OUT;
                    end
                end
                P_OUT: begin
                    // hold the minimum until the previous result has left
                    if (!r_ovalid || i_ready) begin
                        r_out <= r_best;
                        r_best <= '1;
                        r_st <= P_IDLE;
                    end
                end
                default: r_st <= P_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.busy |-> !o_ready) else $error("item taken while segment busy");
    a_done_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.done |-> (r_st == P_SEG1 || r_st == P_SEG2)) else $error("stray done");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state not one-hot");
endmodule
